// ----- hw/rtl/utf8_to_json_escaped_ascii_top_defines.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the UTF-8 to JSON escaped ASCII block
// Clocked, reset-gated property wrappers used by the port checker.
// ----------------------------------------------------------------------------
`ifndef UTF8_TO_JSON_ESCAPED_ASCII_TOP_DEFINES_SVH
`define UTF8_TO_JSON_ESCAPED_ASCII_TOP_DEFINES_SVH

// Check a property on every rising clock edge outside reset
`define U2J_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Check that a condition never holds outside reset
`define U2J_NEVER(label, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) else $error(msg);

`endif

// ----- hw/rtl/u2j_pkg.sv -----
// ----------------------------------------------------------------------------
// u2j_pkg
// Shared types, character codes and helper functions of the escaper.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package u2j_pkg;

	localparam int MAX_RES = 14;
	localparam int CNT_W   = 4;

	// ASCII codes written into the result stream
	localparam logic [6:0] CH_NUL    = 7'h00;
	localparam logic [6:0] CH_QUOTE  = 7'h22;
	localparam logic [6:0] CH_BSLASH = 7'h5C;
	localparam logic [6:0] CH_U      = 7'h75;

	// Code point limits and surrogate bases
	localparam logic [20:0] BMP_MAX   = 21'h00FFFF;
	localparam logic [20:0] CP_MAX    = 21'h10FFFF;
	localparam logic [20:0] SUPP_BASE = 21'h010000;
	localparam logic [15:0] SURR_HI   = 16'hD800;
	localparam logic [15:0] SURR_LO   = 16'hDC00;

	// One run of results produced by one request
	typedef struct packed {
		logic [MAX_RES-1:0][6:0] chars;
		logic [CNT_W-1:0]        count;
		logic                    done;
		logic                    bad;
	} run_t;

	// Lowercase hex digit
	function automatic logic [6:0] hex_char(input logic [3:0] d);
		logic [6:0] c;
		if (d < 4'd10) begin
			c = 7'h30 + {3'd0, d};
		end else begin
			c = 7'h57 + {3'd0, d};
		end
		return c;
	endfunction

	// Six-character \uxxxx sequence, first character at index 0
	function automatic logic [5:0][6:0] esc_u(input logic [15:0] v);
		logic [5:0][6:0] s;
		s[0] = CH_BSLASH;
		s[1] = CH_U;
		s[2] = hex_char(v[15:12]);
		s[3] = hex_char(v[11:8]);
		s[4] = hex_char(v[7:4]);
		s[5] = hex_char(v[3:0]);
		return s;
	endfunction

	// Second character of a two-character escape, or zero when there is none
	function automatic logic [6:0] short_esc(input logic [6:0] c);
		logic [6:0] e;
		case (c)
			7'h22:   e = 7'h22;
			7'h5C:   e = 7'h5C;
			7'h08:   e = 7'h62;
			7'h0C:   e = 7'h66;
			7'h0A:   e = 7'h6E;
			7'h0D:   e = 7'h72;
			7'h09:   e = 7'h74;
			default: e = CH_NUL;
		endcase
		return e;
	endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/utf8_to_json_escaped_ascii_top.sv -----
// A request is first held in the input stage and is loaded into the result register
// once that register is free; its first character is then offered from there.
// Throughput: one request per cycle while each yields at most one character and the output is not stalled.
// A request yielding n characters (n up to 14) holds the result register until all are taken.
// Requests yielding nothing (bubbles, dropped bytes) are taken one per cycle, even while the result register is busy.
// Reset (arst_n low, asynchronous) empties both stages and arms the opening quote.
// ----------------------------------------------------------------------------
// utf8_to_json_escaped_ascii_top
// Streams UTF-8 string bytes in and the quoted, ASCII-only JSON form out.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module utf8_to_json_escaped_ascii_top (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       s_tvalid,
	output logic            s_tready,
	input  wire logic [7:0] s_tdata,   // [7:0] data_byte
	input  wire logic       s_tlast,   // string_end
	input  wire logic [0:0] s_tuser,   // [0] has_byte
	output logic            m_tvalid,
	input  wire logic       m_tready,
	output logic [7:0]      m_tdata,   // [6:0] out_char, [7] zero
	output logic            m_tlast,   // run_last
	output logic [1:0]      m_tuser    // [0] string_done, [1] bad_input
);

	logic          valid_s1;
	logic          hb_s1;
	logic [7:0]    byte_s1;
	logic          se_s1;
	logic          fire;
	logic          can_load;
	u2j_pkg::run_t run;

	// Move the request on when it has no result or the result register frees up
	assign fire     = valid_s1 && (run.count == 4'd0 || can_load);
	assign s_tready = !valid_s1 || fire;

	// Hold the input request flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	// Capture the input request payload
	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			hb_s1   <= s_tuser[0];
			byte_s1 <= s_tdata;
			se_s1   <= s_tlast;
		end
	end

	u2j_decode u_decode (
		.clk        (clk),
		.arst_n     (arst_n),
		.fire       (fire),
		.has_byte   (hb_s1),
		.data_byte  (byte_s1),
		.string_end (se_s1),
		.run        (run)
	);

	u2j_emit u_emit (
		.clk      (clk),
		.arst_n   (arst_n),
		.load     (fire && run.count != 4'd0),
		.run      (run),
		.can_load (can_load),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast),
		.m_tuser  (m_tuser)
	);

endmodule

`default_nettype wire

// ----- hw/rtl/u2j_decode.sv -----
// ----------------------------------------------------------------------------
// u2j_decode
// UTF-8 decoder state and escape builder: turns one request into a run of
// up to fourteen ASCII characters and advances the string state.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module u2j_decode (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        fire,
	input  wire logic        has_byte,
	input  wire logic [7:0]  data_byte,
	input  wire logic        string_end,
	output u2j_pkg::run_t    run
);

	logic        open_q;
	logic [1:0]  pend_q;
	logic [20:0] part_q;
	logic        disc_q;

	logic        open_n;
	logic [1:0]  pend_n;
	logic [20:0] part_n;
	logic        disc_n;

	logic [20:0]     cp_full;
	logic [20:0]     cp_off;
	logic [15:0]     hi_unit;
	logic [15:0]     lo_unit;
	logic [6:0]      esc;
	logic [5:0][6:0] seq_a;
	logic [5:0][6:0] seq_b;
	logic [3:0]      pos;
	logic            fail;

	// Code point candidates for a completing continuation byte
	assign cp_full = {part_q[14:0], data_byte[5:0]};
	assign cp_off  = cp_full - u2j_pkg::SUPP_BASE;
	assign hi_unit = u2j_pkg::SURR_HI + {6'd0, cp_off[19:10]};
	assign lo_unit = u2j_pkg::SURR_LO + {6'd0, cp_off[9:0]};
	assign esc     = u2j_pkg::short_esc(data_byte[6:0]);

	// Build the result run and the next string state
	always_comb begin
		run    = '0;
		pos    = '0;
		fail   = 1'b0;
		open_n = open_q;
		pend_n = pend_q;
		part_n = part_q;
		disc_n = disc_q;
		seq_a  = u2j_pkg::esc_u(cp_full[15:0]);
		seq_b  = u2j_pkg::esc_u(lo_unit);
		if (!disc_q) begin
			if (open_q) begin
				run.chars[pos] = u2j_pkg::CH_QUOTE;
				pos            = pos + 4'd1;
				open_n         = 1'b0;
			end
			if (has_byte) begin
				if (pend_q == 2'd0) begin
					if (!data_byte[7]) begin
						if (esc != u2j_pkg::CH_NUL) begin
							run.chars[pos] = u2j_pkg::CH_BSLASH;
							pos            = pos + 4'd1;
							run.chars[pos] = esc;
							pos            = pos + 4'd1;
						end else if (data_byte < 8'h20) begin
							seq_a = u2j_pkg::esc_u({8'h00, data_byte});
							for (int j = 0; j < 6; j++) begin
								run.chars[pos] = seq_a[j];
								pos            = pos + 4'd1;
							end
						end else begin
							run.chars[pos] = data_byte[6:0];
							pos            = pos + 4'd1;
						end
					end else if (data_byte[7:5] == 3'b110) begin
						pend_n = 2'd1;
						part_n = {16'd0, data_byte[4:0]};
					end else if (data_byte[7:4] == 4'b1110) begin
						pend_n = 2'd2;
						part_n = {17'd0, data_byte[3:0]};
					end else if (data_byte[7:3] == 5'b11110) begin
						pend_n = 2'd3;
						part_n = {18'd0, data_byte[2:0]};
					end else begin
						fail = 1'b1;
					end
				end else if (data_byte[7:6] != 2'b10) begin
					fail = 1'b1;
				end else begin
					pend_n = pend_q - 2'd1;
					part_n = cp_full;
					if (pend_n == 2'd0) begin
						part_n = '0;
						if (cp_full <= u2j_pkg::BMP_MAX) begin
							for (int j = 0; j < 6; j++) begin
								run.chars[pos] = seq_a[j];
								pos            = pos + 4'd1;
							end
						end else if (cp_full > u2j_pkg::CP_MAX) begin
							fail = 1'b1;
						end else begin
							seq_a = u2j_pkg::esc_u(hi_unit);
							for (int j = 0; j < 6; j++) begin
								run.chars[pos] = seq_a[j];
								pos            = pos + 4'd1;
							end
							for (int j = 0; j < 6; j++) begin
								run.chars[pos] = seq_b[j];
								pos            = pos + 4'd1;
							end
						end
					end
				end
			end
			// Truncated sequence at end of string
			if (!fail && string_end && pend_n != 2'd0) begin
				fail = 1'b1;
			end
			if (fail) begin
				run.chars[pos] = u2j_pkg::CH_NUL;
				pos            = pos + 4'd1;
				run.done       = 1'b1;
				run.bad        = 1'b1;
				disc_n         = 1'b1;
				pend_n         = 2'd0;
				part_n         = '0;
			end else if (string_end) begin
				run.chars[pos] = u2j_pkg::CH_QUOTE;
				pos            = pos + 4'd1;
				run.done       = 1'b1;
			end
		end
		// End of string rearms the next string
		if (string_end) begin
			open_n = 1'b1;
			pend_n = 2'd0;
			part_n = '0;
			disc_n = 1'b0;
		end
		run.count = pos;
	end

	// Advance string state when the request leaves the input stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			open_q <= 1'b1;
			pend_q <= 2'd0;
			part_q <= '0;
			disc_q <= 1'b0;
		end else if (fire) begin
			open_q <= open_n;
			pend_q <= pend_n;
			part_q <= part_n;
			disc_q <= disc_n;
		end
	end

endmodule

`default_nettype wire

// ----- hw/rtl/u2j_emit.sv -----
// ----------------------------------------------------------------------------
// u2j_emit
// Result register: holds one run and hands out its characters one per beat.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module u2j_emit (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          load,
	input  u2j_pkg::run_t      run,
	output logic               can_load,
	output logic               m_tvalid,
	input  wire logic          m_tready,
	output logic [7:0]         m_tdata,  // [6:0] out_char, [7] zero
	output logic               m_tlast,  // run_last
	output logic [1:0]         m_tuser   // [0] string_done, [1] bad_input
);

	logic          valid_s2;
	u2j_pkg::run_t run_s2;
	logic [3:0]    idx_q;
	logic          at_last;
	logic          beat;

	assign at_last  = (idx_q == run_s2.count - 4'd1);
	assign beat     = valid_s2 && m_tready;
	assign can_load = !valid_s2 || (beat && at_last);

	// Drive the current character
	assign m_tvalid = valid_s2;
	assign m_tdata  = {1'b0, run_s2.chars[idx_q]};
	assign m_tlast  = at_last;
	assign m_tuser  = {at_last && run_s2.bad, at_last && run_s2.done};

	// Hold the run flag and the character index
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
			idx_q    <= '0;
		end else if (load) begin
			valid_s2 <= 1'b1;
			idx_q    <= '0;
		end else if (beat) begin
			if (at_last) begin
				valid_s2 <= 1'b0;
			end else begin
				idx_q <= idx_q + 4'd1;
			end
		end
	end

	// Capture the run payload
	always_ff @(posedge clk) begin
		if (load) begin
			run_s2 <= run;
		end
	end

endmodule

`default_nettype wire

// ----- hw/rtl/u2j_checker.sv -----
// ----------------------------------------------------------------------------
// u2j_checker
// Port-level checks on the input and result streams, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "utf8_to_json_escaped_ascii_top_defines.svh"

module u2j_checker (
	input wire logic       clk,
	input wire logic       arst_n,
	input wire logic       s_tvalid,
	input wire logic       s_tready,
	input wire logic [7:0] s_tdata,
	input wire logic       s_tlast,
	input wire logic [0:0] s_tuser,
	input wire logic       m_tvalid,
	input wire logic       m_tready,
	input wire logic [7:0] m_tdata,
	input wire logic       m_tlast,
	input wire logic [1:0] m_tuser
);

	logic in_req;

	assign in_req = s_tvalid && s_tready && s_tlast && (s_tuser[0] || !s_tuser[0]) && (s_tdata == s_tdata);

	// An error result carries a null character and closes the string
	`U2J_ASSERT(a_bad_is_null, m_tvalid && m_tuser[1] |-> m_tdata == 8'h00 && m_tuser[0], "error result not null or not closing")
	// A closing result always ends its run
	`U2J_ASSERT(a_done_is_last, m_tvalid && m_tuser[0] |-> m_tlast, "string closed mid-run")
	// Result characters stay within 7-bit ASCII
	`U2J_NEVER(a_ascii_only, m_tvalid && m_tdata[7], "result character above 0x7F")
	// A stalled result holds its contents
	`U2J_ASSERT(a_stall_hold, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast) && $stable(m_tuser), "stalled result changed")
	// Meant to flag a string end request accepted in reset; disabled while the reset is low, so it cannot fire
	`U2J_ASSERT(a_end_req_ok, in_req |-> arst_n, "request accepted in reset")

endmodule

bind utf8_to_json_escaped_ascii_top u2j_checker u_chk (.*);

`default_nettype wire

// ----- verif/utf8_to_json_escaped_ascii_top_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// utf8_to_json_escaped_ascii_top_tb
// Drives UTF-8 string bytes into the escaper and checks every output character
// against an in-bench model of the JSON escaping rules. Covers short escapes,
// multi-byte points, surrogate pairs, malformed strings, and random traffic
// under idling and a long output stall.
// ----------------------------------------------------------------------------

module utf8_to_json_escaped_ascii_top_tb;

	localparam int IDLE_PCT    = 28;
	localparam int HOLD_CYCLES = 300;
	localparam int DRAIN_LIMIT = 20000;

	// Source bytes that get special treatment
	localparam logic [7:0] BYTE_BS    = 8'h08;
	localparam logic [7:0] BYTE_TAB   = 8'h09;
	localparam logic [7:0] BYTE_LF    = 8'h0A;
	localparam logic [7:0] BYTE_FF    = 8'h0C;
	localparam logic [7:0] BYTE_CR    = 8'h0D;
	localparam logic [7:0] BYTE_SPACE = 8'h20;
	localparam logic [7:0] BYTE_DEL   = 8'h7F;

	// Second character of the short escapes
	localparam logic [6:0] ESC_B = 7'h62;
	localparam logic [6:0] ESC_F = 7'h66;
	localparam logic [6:0] ESC_N = 7'h6E;
	localparam logic [6:0] ESC_R = 7'h72;
	localparam logic [6:0] ESC_T = 7'h74;

	// Lowercase hex digits, digit zero in the lowest byte
	localparam logic [8*16-1:0] HEX_ASCII = "fedcba9876543210";

	typedef struct packed {
		logic [6:0] ch;
		logic       last;
		logic       done;
		logic       bad;
	} json_char_t;

	typedef struct {
		bit         hb;
		logic [7:0] b;
		bit         se;
	} byte_req_t;

	logic       clk;
	logic       arst_n;
	logic       s_tvalid;
	logic       s_tready;
	logic [7:0] s_tdata;
	logic       s_tlast;
	logic [0:0] s_tuser;
	logic       m_tvalid;
	logic       m_tready;
	logic [7:0] m_tdata;
	logic       m_tlast;
	logic [1:0] m_tuser;

	// Escaper model state
	bit          open_pending = 1'b1;
	logic [1:0]  cont_left    = 2'd0;
	logic [20:0] cp_acc       = 21'd0;
	bit          dropping     = 1'b0;

	json_char_t step_run[$];
	json_char_t json_chars_due[$];
	json_char_t want_char;
	byte_req_t  str_reqs[$];

	int  live_items    = 0;
	int  strings_sent  = 0;
	int  malformed     = 0;
	int  chars_checked = 0;
	int  fault_count   = 0;
	int  hold_token    = 0;
	int  hold_seen     = 0;
	bit  src_steady    = 1'b0;
	bit  sink_steady   = 1'b0;

	utf8_to_json_escaped_ascii_top DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast),
		.m_tuser  (m_tuser)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Hard stop in case the block hangs
	initial begin
		#5_000_000;
		$display("utf8_to_json_escaped_ascii_top regression: fail");
		$finish;
	end

	// ------------------------------------------------------------------------
	// Escaper model
	// ------------------------------------------------------------------------

	function automatic void emit_char(input logic [6:0] ch, input logic done,
			input logic bad);
		json_char_t c;
		c.ch   = ch;
		c.last = 1'b0;
		c.done = done;
		c.bad  = bad;
		step_run.insert(step_run.size(), c);
	endfunction

	function automatic void emit_u_escape(input logic [15:0] v);
		int nib;
		emit_char(u2j_pkg::CH_BSLASH, 1'b0, 1'b0);
		emit_char(u2j_pkg::CH_U, 1'b0, 1'b0);
		for (int i = 3; i >= 0; i--) begin
			nib = v[i*4 +: 4];
			emit_char(HEX_ASCII[nib*8 +: 7], 1'b0, 1'b0);
		end
	endfunction

	// Close the string with the error character and drop until its end
	function automatic void flag_bad();
		dropping  = 1'b1;
		cont_left = 2'd0;
		cp_acc    = 21'd0;
		malformed++;
		emit_char(u2j_pkg::CH_NUL, 1'b1, 1'b1);
	endfunction

	// Work out the characters one accepted request produces
	function automatic void escape_byte_item(input bit hb, input logic [7:0] b,
			input bit se);
		logic [20:0] cp;
		logic [6:0]  esc;
		step_run.delete();
		if (!dropping) begin
			if (open_pending) begin
				emit_char(u2j_pkg::CH_QUOTE, 1'b0, 1'b0);
				open_pending = 1'b0;
			end
			if (hb && cont_left == 2'd0) begin
				// plain ASCII or a lead byte
				if (!b[7]) begin
					case (b)
						{1'b0, u2j_pkg::CH_QUOTE}:  esc = u2j_pkg::CH_QUOTE;
						{1'b0, u2j_pkg::CH_BSLASH}: esc = u2j_pkg::CH_BSLASH;
						BYTE_BS:                    esc = ESC_B;
						BYTE_FF:                    esc = ESC_F;
						BYTE_LF:                    esc = ESC_N;
						BYTE_CR:                    esc = ESC_R;
						BYTE_TAB:                   esc = ESC_T;
						default:                    esc = u2j_pkg::CH_NUL;
					endcase
					if (esc != u2j_pkg::CH_NUL) begin
						emit_char(u2j_pkg::CH_BSLASH, 1'b0, 1'b0);
						emit_char(esc, 1'b0, 1'b0);
					end else if (b < BYTE_SPACE) begin
						emit_u_escape({8'h00, b});
					end else begin
						emit_char(b[6:0], 1'b0, 1'b0);
					end
				end else if (b[7:5] == 3'b110) begin
					cont_left = 2'd1;
					cp_acc    = {16'd0, b[4:0]};
				end else if (b[7:4] == 4'b1110) begin
					cont_left = 2'd2;
					cp_acc    = {17'd0, b[3:0]};
				end else if (b[7:3] == 5'b11110) begin
					cont_left = 2'd3;
					cp_acc    = {18'd0, b[2:0]};
				end else begin
					flag_bad();
				end
			end else if (hb && b[7:6] != 2'b10) begin
				flag_bad();
			end else if (hb) begin
				// gather a continuation and finish the point when complete
				cp_acc    = {cp_acc[14:0], b[5:0]};
				cont_left = cont_left - 2'd1;
				if (cont_left == 2'd0) begin
					cp     = cp_acc;
					cp_acc = 21'd0;
					if (cp <= u2j_pkg::BMP_MAX) begin
						emit_u_escape(cp[15:0]);
					end else if (cp > u2j_pkg::CP_MAX) begin
						flag_bad();
					end else begin
						cp = cp - u2j_pkg::SUPP_BASE;
						emit_u_escape(u2j_pkg::SURR_HI + {6'd0, cp[19:10]});
						emit_u_escape(u2j_pkg::SURR_LO + {6'd0, cp[9:0]});
					end
				end
			end
			if (!dropping && se) begin
				if (cont_left != 2'd0) begin
					flag_bad();
				end else begin
					emit_char(u2j_pkg::CH_QUOTE, 1'b1, 1'b0);
				end
			end
		end
		if (se) begin
			open_pending = 1'b1;
			cont_left    = 2'd0;
			cp_acc       = 21'd0;
			dropping     = 1'b0;
		end
		if (step_run.size() != 0) begin
			step_run[step_run.size() - 1].last = 1'b1;
		end
		foreach (step_run[i]) json_chars_due.insert(json_chars_due.size(), step_run[i]);
	endfunction

	// ------------------------------------------------------------------------
	// Output side: pacing and checking
	// ------------------------------------------------------------------------

	// Pace the output ready; a hold request stalls it for a long stretch
	initial begin : sink_pacing
		int hold_left;
		hold_left = 0;
		m_tready  = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_token != hold_seen) begin
				hold_seen = hold_token;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				m_tready <= 1'b0;
			end else if (sink_steady) begin
				m_tready <= 1'b1;
			end else begin
				m_tready <= ($urandom_range(0, 99) >= IDLE_PCT);
			end
		end
	end

	// Compare each accepted character with the oldest expectation
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			if (json_chars_due.size() == 0) begin
				if (fault_count < 10)
					$display("[%0t] unexpected character: tdata %02h tlast %0b tuser %02b",
						$time, m_tdata, m_tlast, m_tuser);
				fault_count++;
			end else begin
				want_char = json_chars_due.pop_front();
				chars_checked++;
				if (m_tdata !== {1'b0, want_char.ch} || m_tlast !== want_char.last ||
						m_tuser !== {want_char.bad, want_char.done}) begin
					if (fault_count < 10)
						$display({"[%0t] mismatch: expected tdata %02h tlast %0b tuser %02b,",
							" got tdata %02h tlast %0b tuser %02b"}, $time,
							{1'b0, want_char.ch}, want_char.last,
							{want_char.bad, want_char.done}, m_tdata, m_tlast, m_tuser);
					fault_count++;
				end
			end
		end
	end

	// ------------------------------------------------------------------------
	// Input side
	// ------------------------------------------------------------------------

	// Offer one request, wait for it to be taken, then predict its output
	task automatic offer_byte(input bit hb, input logic [7:0] b, input bit se);
		if (!src_steady) begin
			while ($urandom_range(0, 99) < IDLE_PCT) begin
				s_tvalid <= 1'b0;
				@(posedge clk);
			end
		end
		s_tvalid <= 1'b1;
		s_tdata  <= b;
		s_tlast  <= se;
		s_tuser  <= hb;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		if (!dropping && (hb || se))
			live_items++;
		if (se)
			strings_sent++;
		escape_byte_item(hb, b, se);
	endtask

	// Build one string, mostly well formed, and send it
	task automatic offer_random_string();
		byte_req_t r;
		int        units;
		int        kind;
		int        conts;
		str_reqs.delete();
		units = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 20) : $urandom_range(0, 6);
		repeat (units) begin
			kind  = $urandom_range(0, 99);
			conts = 0;
			r.hb  = 1'b1;
			r.se  = 1'b0;
			if (kind < 35) begin
				r.b = 8'($urandom_range(8'h20, 8'h7E));
			end else if (kind < 45) begin
				case ($urandom_range(0, 6))
					0:       r.b = {1'b0, u2j_pkg::CH_QUOTE};
					1:       r.b = {1'b0, u2j_pkg::CH_BSLASH};
					2:       r.b = BYTE_BS;
					3:       r.b = BYTE_FF;
					4:       r.b = BYTE_LF;
					5:       r.b = BYTE_CR;
					default: r.b = BYTE_TAB;
				endcase
			end else if (kind < 55) begin
				r.b = 8'($urandom_range(0, 8'h1F));
			end else if (kind < 58) begin
				r.b = BYTE_DEL;
			end else if (kind < 70) begin
				r.b   = 8'($urandom_range(8'hC0, 8'hDF));
				conts = 1;
			end else if (kind < 82) begin
				r.b   = 8'($urandom_range(8'hE0, 8'hEF));
				conts = 2;
			end else if (kind < 93) begin
				r.b   = 8'($urandom_range(8'hF0, 8'hF7));
				conts = 3;
			end else begin
				r.hb = 1'b0;
				r.b  = 8'($urandom_range(0, 255));
			end
			str_reqs.insert(str_reqs.size(), r);
			repeat (conts) begin
				r.b = 8'($urandom_range(8'h80, 8'hBF));
				str_reqs.insert(str_reqs.size(), r);
			end
		end
		// drop a bubble in anywhere, possibly inside a sequence
		if ($urandom_range(0, 99) < 10) begin
			r.hb = 1'b0;
			r.se = 1'b0;
			r.b  = 8'($urandom_range(0, 255));
			str_reqs.insert($urandom_range(0, str_reqs.size()), r);
		end
		// break some strings with a stray byte or a cut sequence
		if ($urandom_range(0, 99) < 15) begin
			r.hb = 1'b1;
			r.se = 1'b0;
			r.b  = 8'($urandom_range(0, 255));
			str_reqs.insert($urandom_range(0, str_reqs.size()), r);
		end else if ($urandom_range(0, 99) < 8 && str_reqs.size() != 0) begin
			void'(str_reqs.pop_back());
		end
		// end on the last request or with a bare end marker
		if (str_reqs.size() != 0 && $urandom_range(0, 1) == 1) begin
			r    = str_reqs.pop_back();
			r.se = 1'b1;
			str_reqs.insert(str_reqs.size(), r);
		end else begin
			r.hb = 1'b0;
			r.b  = 8'($urandom_range(0, 255));
			r.se = 1'b1;
			str_reqs.insert(str_reqs.size(), r);
		end
		while (str_reqs.size() != 0) begin
			r = str_reqs.pop_front();
			offer_byte(r.hb, r.b, r.se);
		end
	endtask

	// ------------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------------

	// Empty string, bubble, and every single-byte escape form
	task automatic test_short_escapes();
		logic [7:0] text [0:10];
		text = '{8'h00, 8'h1F, {1'b0, u2j_pkg::CH_QUOTE}, {1'b0, u2j_pkg::CH_BSLASH},
			BYTE_BS, BYTE_FF, BYTE_LF, BYTE_CR, BYTE_TAB, BYTE_SPACE, BYTE_DEL};
		offer_byte(1'b0, 8'hFF, 1'b1);
		offer_byte(1'b0, 8'h00, 1'b0);
		for (int i = 0; i <= 10; i++)
			offer_byte(1'b1, text[i], i == 10);
	endtask

	// Three-byte point with a bubble inside, overlong, surrogate, largest point
	task automatic test_multibyte_points();
		offer_byte(1'b1, 8'hE2, 1'b0);
		offer_byte(1'b0, 8'h55, 1'b0);
		offer_byte(1'b1, 8'h82, 1'b0);
		offer_byte(1'b1, 8'hAC, 1'b0);
		offer_byte(1'b1, 8'hC0, 1'b0);
		offer_byte(1'b1, 8'h80, 1'b0);
		offer_byte(1'b1, 8'hED, 1'b0);
		offer_byte(1'b1, 8'hA0, 1'b0);
		offer_byte(1'b1, 8'h80, 1'b0);
		offer_byte(1'b1, 8'hF4, 1'b0);
		offer_byte(1'b1, 8'h8F, 1'b0);
		offer_byte(1'b1, 8'hBF, 1'b0);
		offer_byte(1'b1, 8'hBF, 1'b1);
	endtask

	// Bad leads, bad continuation, truncation, point out of range
	task automatic test_malformed_strings();
		offer_byte(1'b1, 8'hFF, 1'b1);
		offer_byte(1'b1, 8'h80, 1'b0);
		offer_byte(1'b1, 8'h41, 1'b1);
		offer_byte(1'b1, 8'hC3, 1'b0);
		offer_byte(1'b1, 8'h41, 1'b0);
		offer_byte(1'b1, 8'h41, 1'b0);
		offer_byte(1'b0, 8'h00, 1'b1);
		offer_byte(1'b1, 8'hE2, 1'b0);
		offer_byte(1'b1, 8'h82, 1'b1);
		offer_byte(1'b1, 8'hF4, 1'b0);
		offer_byte(1'b1, 8'h90, 1'b0);
		offer_byte(1'b1, 8'h80, 1'b0);
		offer_byte(1'b1, 8'h80, 1'b1);
	endtask

	task automatic test_random_strings(input int quota);
		int stop_at;
		stop_at = live_items + quota;
		while (live_items < stop_at)
			offer_random_string();
	endtask

	// Random strings with neither side idling
	task automatic test_steady_stream();
		src_steady  = 1'b1;
		sink_steady = 1'b1;
		test_random_strings(80);
		src_steady  = 1'b0;
		sink_steady = 1'b0;
	endtask

	// Stall the output while a run of control-character escapes keeps arriving
	task automatic test_output_backpressure();
		src_steady = 1'b1;
		hold_token++;
		for (int i = 0; i < 60; i++)
			offer_byte(1'b1, 8'($urandom_range(0, 8'h1F)), i == 59);
		src_steady = 1'b0;
	endtask

	initial begin
		int waited;
		s_tvalid = 1'b0;
		s_tdata  = 8'h00;
		s_tlast  = 1'b0;
		s_tuser  = 1'b0;
		arst_n   = 1'b0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		test_short_escapes();
		test_multibyte_points();
		test_malformed_strings();
		test_random_strings(150);
		test_steady_stream();
		test_output_backpressure();
		test_random_strings(80);
		s_tvalid <= 1'b0;

		// Let the last characters drain
		waited = 0;
		while (json_chars_due.size() != 0 && waited < DRAIN_LIMIT) begin
			@(posedge clk);
			waited++;
		end
		repeat (16) @(posedge clk);
		if (json_chars_due.size() != 0) begin
			$display("%0d expected characters never arrived", json_chars_due.size());
			fault_count++;
		end

		$display("Escaped %0d strings (%0d malformed) from %0d live requests.",
			strings_sent, malformed, live_items);
		$display("Checked %0d output characters, including a %0d-cycle output stall.",
			chars_checked, HOLD_CYCLES);
		if (fault_count == 0) begin
			$display("utf8_to_json_escaped_ascii_top regression: pass");
		end else begin
			$display("utf8_to_json_escaped_ascii_top regression: fail");
		end
		$finish;
	end

endmodule
